### rtl/olist_pkg.sv
`timescale 1ns / 1ps
// olist_pkg: shared types and codes for the ordered list block
// command and response payload structs, operation and status codes
// no dependencies
package olist_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         position;
    logic signed [31:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [7:0]         found_position;
    logic [7:0]         entry_count_out;
  } rsp_t;

endpackage

### rtl/ordered_list_insert_delete_find.sv
`timescale 1ns / 1ps
// ordered_list_insert_delete_find: ordered list of signed words in one memory
// append, insert, delete and find over a synchronous single-port-write store
// depends on olist_pkg
//
//   channel  | signals             | transfer
//   ---------+---------------------+------------------------------------
//   command  | start, busy, cmd    | edge with start high and busy low
//   response | done, rsp           | edge ending the single done cycle
//
// append and every error case finish in the accept cycle; done is raised in the cycle after
// find reads the entries in order from the first (one memory read per entry)
// insert and delete do one read and one
// write-back per moved entry, overlapped, through the one memory port pair
// reset clears the entry count and the control state; memory contents are never cleared
// busy stays high until the response is posted; the response cannot be stalled
module ordered_list_insert_delete_find #(
  parameter int LIST_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  olist_pkg::cmd_t   cmd,
  output logic              done,
  output olist_pkg::rsp_t   rsp
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int XW = ((CW > 8) ? CW : 8) + 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        ptr;
  logic [CW-1:0]        rem;
  logic                 pend;
  logic [AW-1:0]        pend_addr;
  logic                 first;
  logic                 is_del;
  logic [AW-1:0]        ins_addr;
  logic signed [31:0]   val;
  logic signed [31:0]   removed;

  logic signed [31:0]   mem [LIST_DEPTH];
  logic signed [31:0]   rd_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic signed [31:0]   mem_wd;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [XW-1:0]        pos_x;
  logic [XW-1:0]        cnt_x;
  logic                 ins_bad;
  logic                 del_bad;
  logic                 hit;
  logic [AW:0]          hit_pos;
  logic                 fast_done;
  logic                 append_ok;
  logic [1:0]           fast_status;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign full    = (count == CW'(LIST_DEPTH));
  assign empty   = (count == '0);
  assign pos_x   = XW'(cmd.position);
  assign cnt_x   = XW'(count);
  assign ins_bad = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
  assign del_bad = (pos_x == '0) || (pos_x > cnt_x);
  assign hit     = pend && (rd_data == val);
  assign hit_pos = {1'b0, pend_addr} + (AW+1)'(1);

  // outcome of a command taken in idle: answered at once or walked
  always_comb begin
    fast_done   = 1'b1;
    append_ok   = 1'b0;
    fast_status = olist_pkg::ST_OK;
    case (cmd.opcode)
      olist_pkg::OP_APPEND: begin
        if (full) begin
          fast_status = olist_pkg::ST_FULL;
        end else begin
          append_ok = 1'b1;
        end
      end
      olist_pkg::OP_INSERT: begin
        if (full) begin
          fast_status = olist_pkg::ST_FULL;
        end else if (ins_bad) begin
          fast_status = olist_pkg::ST_BADPOS;
        end else begin
          fast_done = 1'b0;
        end
      end
      olist_pkg::OP_DELETE: begin
        if (empty) begin
          fast_status = olist_pkg::ST_EMPTY;
        end else if (del_bad) begin
          fast_status = olist_pkg::ST_BADPOS;
        end else begin
          fast_done = 1'b0;
        end
      end
      olist_pkg::OP_FIND: begin
        if (empty) begin
          fast_status = olist_pkg::ST_EMPTY;
        end else begin
          fast_done = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // single read port and single write port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr;
    mem_we  = 1'b0;
    mem_wa  = pend_addr;
    mem_wd  = rd_data;
    case (state)
      S_IDLE: begin
        if (accept && cmd.opcode == olist_pkg::OP_APPEND && !full) begin
          mem_we = 1'b1;
          mem_wa = AW'(count);
          mem_wd = cmd.item_value;
        end
      end
      S_SCAN: begin
        rd_en = !hit && (rem != '0);
      end
      S_SHIFT: begin
        rd_en  = (rem != '0);
        mem_we = pend && !first;
      end
      S_FINISH: begin
        if (!is_del) begin
          mem_we = 1'b1;
          mem_wa = ins_addr;
          mem_wd = val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
      first <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= accept && fast_done;
          if (accept) begin
            rsp.status          <= fast_status;
            rsp.removed_value   <= '0;
            rsp.found_position  <= '0;
            rsp.entry_count_out <= append_ok ? 8'(count + 1'b1) : 8'(count);
            val                 <= cmd.item_value;
            pend                <= 1'b0;
            removed             <= '0;
            ins_addr            <= AW'(pos_x - XW'(1));
            rem                 <= (cmd.opcode == olist_pkg::OP_FIND) ? count
                                   : CW'(cnt_x - pos_x + XW'(1));
            // insert walks down from the last entry, each one moving up a slot;
            // delete reads the removed entry first, the rest move down a slot
            is_del              <= (cmd.opcode == olist_pkg::OP_DELETE);
            first               <= (cmd.opcode == olist_pkg::OP_DELETE);
            if (cmd.opcode == olist_pkg::OP_FIND) begin
              ptr <= '0;
            end else if (cmd.opcode == olist_pkg::OP_INSERT) begin
              ptr <= AW'(cnt_x - XW'(1));
            end else begin
              ptr <= AW'(pos_x - XW'(1));
            end
            if (append_ok) begin
              count <= CW'(count + 1'b1);
            end
            if (!fast_done) begin
              if (cmd.opcode == olist_pkg::OP_FIND) begin
                state <= S_SCAN;
              end else begin
                state <= S_SHIFT;
              end
            end
          end
        end
        S_SCAN: begin
          done <= hit || (rem == '0);
          if (hit) begin
            rsp.found_position <= 8'(hit_pos);
            pend               <= 1'b0;
            state              <= S_IDLE;
          end else if (rem != '0) begin
            pend      <= 1'b1;
            pend_addr <= ptr;
            ptr       <= AW'(ptr + 1'b1);
            rem       <= CW'(rem - 1'b1);
          end else begin
            pend  <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_SHIFT: begin
          done <= 1'b0;
          if (pend && first) begin
            removed <= rd_data;
            first   <= 1'b0;
          end
          if (rem != '0) begin
            pend      <= 1'b1;
            pend_addr <= is_del ? AW'(ptr - 1'b1) : AW'(ptr + 1'b1);
            ptr       <= is_del ? AW'(ptr + 1'b1) : AW'(ptr - 1'b1);
            rem       <= CW'(rem - 1'b1);
          end else begin
            pend  <= 1'b0;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          done <= 1'b1;
          if (is_del) begin
            count               <= CW'(count - 1'b1);
            rsp.entry_count_out <= 8'(count - 1'b1);
            rsp.removed_value   <= removed;
          end else begin
            count               <= CW'(count + 1'b1);
            rsp.entry_count_out <= 8'(count + 1'b1);
          end
          state <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(LIST_DEPTH))
    else $error("entry count above list depth");

  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |=> (done && state == S_IDLE))
    else $error("finish did not post a response");

  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.entry_count_out == 8'(count)))
    else $error("reported count differs from stored count");

  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == olist_pkg::OP_APPEND && !full)
      |=> (count == CW'($past(count) + 1'b1)))
    else $error("append did not grow the list");

endmodule

### bench/ordered_list_insert_delete_find_test.sv
`timescale 1ns / 1ps
// ordered_list_insert_delete_find_test: self-checking bench for the ordered list block
// drives append, insert, delete and find commands and predicts every response
// depends on olist_pkg and ordered_list_insert_delete_find
module ordered_list_insert_delete_find_test;
  import olist_pkg::*;

  localparam int LIST_DEPTH   = 128;
  localparam int RANDOM_ITEMS = 1100;
  localparam int LIMIT_CYCLES = 2_000_000;

  // mirror of the list contents, plus the responses still owed by the block
  class list_scoreboard;
    logic signed [31:0] store [LIST_DEPTH];
    int unsigned        count = 0;
    rsp_t               owed_q [$];
    int                 errors = 0;

    function void note_command(cmd_t c);
      rsp_t        r;
      int unsigned pos;
      pos = c.position;
      r = '0;
      case (c.opcode)
        OP_APPEND: begin
          if (count >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            store[count] = c.item_value;
            count++;
            r.status = ST_OK;
          end
        end
        OP_INSERT: begin
          if (count >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else if (pos < 1 || pos > count + 1) begin
            r.status = ST_BADPOS;
          end else begin
            for (int unsigned i = count; i >= pos; i--) store[i] = store[i - 1];
            store[pos - 1] = c.item_value;
            count++;
            r.status = ST_OK;
          end
        end
        OP_DELETE: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else if (pos < 1 || pos > count) begin
            r.status = ST_BADPOS;
          end else begin
            r.removed_value = store[pos - 1];
            for (int unsigned i = pos; i < count; i++) store[i - 1] = store[i];
            count--;
            r.status = ST_OK;
          end
        end
        default: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_OK;
            // first match only
            for (int unsigned i = 0; i < count; i++) begin
              if (store[i] == c.item_value && r.found_position == 0) begin
                r.found_position = 8'(i + 1);
              end
            end
          end
        end
      endcase
      r.entry_count_out = 8'(count);
      owed_q.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (owed_q.size() == 0) begin
        $error("response with none outstanding: status %0d count %0d",
               got.status, got.entry_count_out);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.removed_value !== want.removed_value) begin
        $error("removed_value: expected %0d, got %0d", want.removed_value,
               got.removed_value);
        errors++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position: expected %0d, got %0d", want.found_position,
               got.found_position);
        errors++;
      end
      if (got.entry_count_out !== want.entry_count_out) begin
        $error("entry_count_out: expected %0d, got %0d", want.entry_count_out,
               got.entry_count_out);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic done;
  rsp_t rsp;

  list_scoreboard sb;
  bit             growing = 1'b1;
  int unsigned    items_sent = 0;
  int unsigned    burst, gap, fill;
  bit             drained_midway = 1'b0;

  ordered_list_insert_delete_find #(
    .LIST_DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
  );

  always #2 clk = ~clk;

  // response is checked before the new transfer is noted: it belongs to an older command
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) sb.check_response(rsp);
      if (start && busy === 1'b0) sb.note_command(cmd);
    end
  end

  task automatic drive(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic send_cmd(input logic [1:0] op, input logic [7:0] pos,
                          input logic signed [31:0] val);
    cmd_t c;
    c.opcode     = op;
    c.position   = pos;
    c.item_value = val;
    @(negedge clk);
    drive(c);
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) @(negedge clk) start <= 1'b0;
  endtask

  task automatic wait_for_results();
    idle_cycles(1);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // mostly legal positions, with edges, zero and out-of-range values mixed in
  task automatic send_random();
    cmd_t        c;
    int unsigned n, roll, lim;
    @(negedge clk);
    n = sb.count;
    if (n >= LIST_DEPTH) growing = 1'b0;
    else if (n == 0) growing = 1'b1;
    else if ($urandom_range(0, 99) < 2) growing = !growing;

    roll = $urandom_range(0, 99);
    if (growing) begin
      c.opcode = roll < 35 ? OP_APPEND : roll < 70 ? OP_INSERT : roll < 82 ? OP_DELETE : OP_FIND;
    end else begin
      c.opcode = roll < 10 ? OP_APPEND : roll < 25 ? OP_INSERT : roll < 75 ? OP_DELETE : OP_FIND;
    end

    lim  = (c.opcode == OP_INSERT) ? n + 1 : n;
    roll = $urandom_range(0, 99);
    if (c.opcode == OP_APPEND || c.opcode == OP_FIND || roll < 8) begin
      c.position = 8'($urandom_range(0, 255));
    end else if (roll < 12) begin
      c.position = '0;
    end else if (roll < 20) begin
      c.position = 8'(lim + 1);
    end else if (roll < 28 || lim == 0) begin
      c.position = 8'(lim);
    end else begin
      c.position = 8'($urandom_range(1, lim));
    end

    // small pool so duplicates and find hits are common
    roll = $urandom_range(0, 99);
    if (c.opcode == OP_FIND && n > 0 && roll < 50) begin
      c.item_value = sb.store[$urandom_range(0, n - 1)];
    end else if (roll < 30) begin
      c.item_value = int'($urandom_range(0, 15)) - 8;
    end else if (roll < 34) begin
      c.item_value = roll[0] ? 32'h7fff_ffff : 32'h8000_0000;
    end else begin
      c.item_value = $urandom;
    end
    items_sent++;
    drive(c);
  endtask

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("ordered_list_insert_delete_find regression: fail");
    $finish;
  end

  initial begin
    sb    = new;
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // empty list and position edges
    send_cmd(OP_FIND,   8'd0,   32'sd0);
    send_cmd(OP_DELETE, 8'd1,   32'sd0);
    send_cmd(OP_INSERT, 8'd0,   32'sd1);
    send_cmd(OP_INSERT, 8'd2,   32'sd1);
    send_cmd(OP_INSERT, 8'd1,   32'h7fff_ffff);
    send_cmd(OP_APPEND, 8'd255, 32'h8000_0000);
    send_cmd(OP_INSERT, 8'd3,   -32'sd1);
    send_cmd(OP_INSERT, 8'd1,   32'sd5);
    send_cmd(OP_INSERT, 8'd2,   32'sd5);
    send_cmd(OP_FIND,   8'd77,  32'sd5);
    send_cmd(OP_FIND,   8'd255, 32'sd12345);
    send_cmd(OP_DELETE, 8'd0,   32'sd0);
    send_cmd(OP_DELETE, 8'd6,   32'sd0);
    send_cmd(OP_DELETE, 8'd5,   32'sd0);
    send_cmd(OP_DELETE, 8'd1,   32'sd0);
    send_cmd(OP_FIND,   8'd0,   32'sd5);
    send_cmd(OP_FIND,   8'd3,   32'h8000_0000);
    send_cmd(OP_APPEND, 8'd0,   32'sd0);
    send_cmd(OP_INSERT, 8'd255, 32'sd9);
    send_cmd(OP_DELETE, 8'd255, 32'sd0);
    send_cmd(OP_DELETE, 8'd2,   32'sd0);
    wait_for_results();

    // fill to capacity, then hit the full and boundary cases
    fill = LIST_DEPTH - sb.count;
    repeat (fill) send_cmd(OP_APPEND, 8'($urandom_range(0, 255)), $urandom);
    send_cmd(OP_APPEND, 8'd0,   32'sd7);
    send_cmd(OP_INSERT, 8'd1,   32'sd7);
    send_cmd(OP_INSERT, 8'd0,   32'sd7);
    send_cmd(OP_INSERT, 8'd129, 32'sd7);
    send_cmd(OP_DELETE, 8'd129, 32'sd0);
    send_cmd(OP_DELETE, 8'd128, 32'sd0);
    send_cmd(OP_INSERT, 8'd128, 32'sd7);
    send_cmd(OP_FIND,   8'd0,   32'sd7);
    send_cmd(OP_DELETE, 8'd1,   32'sd0);

    // bursts of random length separated by random gaps, some back to back
    while (items_sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (burst) send_random();
      idle_cycles(gap);
      if (!drained_midway && items_sent > RANDOM_ITEMS / 2) begin
        wait_for_results();
        drained_midway = 1'b1;
      end
    end

    wait_for_results();
    idle_cycles(LIST_DEPTH + 8);
    if (sb.pending() != 0) begin
      $error("%0d responses never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("ordered_list_insert_delete_find regression: pass");
    end else begin
      $display("ordered_list_insert_delete_find regression: fail");
    end
    $finish;
  end

endmodule
